// ----- rtl/tcffc_pkg.sv -----
// Shared types and constants of the tagged-count frame frequency calculator.
`default_nettype none

package tcffc_pkg;

  // Tag bytes that select which count a frame carries
  localparam logic [7:0] TagReference = 8'hAA;
  localparam logic [7:0] TagGated     = 8'hBB;
  localparam logic [7:0] TagClock     = 8'hCC;

  localparam int unsigned FrameBytes       = 5;
  localparam int unsigned CountW           = 32;
  localparam int unsigned FrameCntW        = 4;
  localparam int unsigned BcdFieldW        = 60;
  localparam int unsigned QueueDepth       = 2;
  localparam int unsigned FramesPerUpdateD = 3;
  localparam int unsigned DigitCountD      = 15;

  // One received frame
  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic [7:0] byte_e;
  } frame_t;

  // One calculation result
  typedef struct packed {
    logic [CountW-1:0]    frequency;
    logic [BcdFieldW-1:0] bcd_digits;
    logic                 divide_by_zero;
    logic                 saturated;
  } result_t;

  // Snapshot of the three counts handed from front to back
  typedef struct packed {
    logic [CountW-1:0] reference_count;
    logic [CountW-1:0] gated_count;
    logic [CountW-1:0] clock_count;
  } job_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/tcffc_fifo.sv -----
// Short job queue between the frame front end and the arithmetic back end.
`default_nettype none

module tcffc_fifo #(
  parameter int unsigned Width = 96,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] pop_data_o,
  output tcffc_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue fill beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/tcffc_front.sv -----
// Front end: accepts frames, decodes the tag, keeps the counts and queues jobs.
`default_nettype none

module tcffc_front #(
  parameter int unsigned FramesPerUpdate = tcffc_pkg::FramesPerUpdateD
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire tcffc_pkg::frame_t        in_data_i,
  input  wire tcffc_pkg::queue_status_t q_status_i,
  output logic                          push_o,
  output tcffc_pkg::job_t               job_o
);

  localparam int unsigned CntW = tcffc_pkg::FrameCntW;
  localparam int unsigned NB   = tcffc_pkg::FrameBytes;

  logic [tcffc_pkg::CountW-1:0] ref_q, ref_d, gat_q, gat_d, clk_cnt_q, clk_cnt_d;
  logic [CntW-1:0]              frm_q, frm_d, frm_inc;
  logic [7:0]                   b [NB];
  logic [tcffc_pkg::CountW-1:0] cnt_at [NB];
  logic                         hit_ref, hit_gat, hit_clk;
  logic [tcffc_pkg::CountW-1:0] val_ref, val_gat, val_clk;
  logic                         accept;

  assign b[0] = in_data_i.byte_a;
  assign b[1] = in_data_i.byte_b;
  assign b[2] = in_data_i.byte_c;
  assign b[3] = in_data_i.byte_d;
  assign b[4] = in_data_i.byte_e;

  // Take the four bytes after each position, wrapping within the frame
  always_comb begin
    for (int p = 0; p < NB; p++) begin
      cnt_at[p] = {b[(p + 1) % NB], b[(p + 2) % NB], b[(p + 3) % NB], b[(p + 4) % NB]};
    end
  end

  // Find the first position of each tag; scan downward so the lowest wins
  always_comb begin
    hit_ref = 1'b0;
    hit_gat = 1'b0;
    hit_clk = 1'b0;
    val_ref = '0;
    val_gat = '0;
    val_clk = '0;
    for (int p = NB - 1; p >= 0; p--) begin
      if (b[p] == tcffc_pkg::TagReference) begin
        hit_ref = 1'b1;
        val_ref = cnt_at[p];
      end
      if (b[p] == tcffc_pkg::TagGated) begin
        hit_gat = 1'b1;
        val_gat = cnt_at[p];
      end
      if (b[p] == tcffc_pkg::TagClock) begin
        hit_clk = 1'b1;
        val_clk = cnt_at[p];
      end
    end
  end

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign frm_inc    = frm_q + CntW'(1);

  // Update the count the tag selects and advance the frame count
  always_comb begin
    ref_d     = ref_q;
    gat_d     = gat_q;
    clk_cnt_d = clk_cnt_q;
    frm_d     = frm_q;
    push_o    = 1'b0;
    if (accept) begin
      if (hit_ref) begin
        ref_d = val_ref;
      end else if (hit_gat) begin
        gat_d = val_gat;
      end else if (hit_clk) begin
        clk_cnt_d = val_clk;
      end
      if (frm_inc == CntW'(FramesPerUpdate)) begin
        frm_d  = '0;
        push_o = 1'b1;
      end else begin
        frm_d = frm_inc;
      end
    end
  end

  assign job_o.reference_count = ref_d;
  assign job_o.gated_count     = gat_d;
  assign job_o.clock_count     = clk_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q     <= '0;
      gat_q     <= '0;
      clk_cnt_q <= '0;
      frm_q     <= '0;
    end else begin
      ref_q     <= ref_d;
      gat_q     <= gat_d;
      clk_cnt_q <= clk_cnt_d;
      frm_q     <= frm_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tcffc_back.sv -----
// Back end: multiply, iterative divide, saturation and BCD conversion.
`default_nettype none

module tcffc_back #(
  parameter int unsigned DigitCount = tcffc_pkg::DigitCountD
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tcffc_pkg::queue_status_t q_status_i,
  input  wire tcffc_pkg::job_t          job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output tcffc_pkg::result_t            out_data_o
);

  localparam int unsigned W     = tcffc_pkg::CountW;
  localparam int unsigned BcdW  = 4 * DigitCount;
  localparam int unsigned StepW = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_BCD,
    S_LOAD
  } state_e;

  state_e              state_q;
  logic [2*W-1:0]      prod_q;
  logic [W-1:0]        ref_q, rem_q, sh_q, freq_q;
  logic [BcdW-1:0]     bcd_q, bcd_adj;
  logic [StepW-1:0]    step_q;
  logic                dz_q, sat_q;
  logic                out_valid_q;
  tcffc_pkg::result_t  out_q;
  logic [W:0]          trial, trial_sub;
  logic                qbit;
  logic                load_out;

  // One restoring divide step
  assign trial     = {rem_q, sh_q[W-1]};
  assign trial_sub = trial - {1'b0, ref_q};
  assign qbit      = (trial >= {1'b0, ref_q});

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DigitCount; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign pop_o       = (state_q == S_IDLE) && !q_status_i.empty;
  assign load_out    = (state_q == S_LOAD) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prod_q      <= '0;
      ref_q       <= '0;
      rem_q       <= '0;
      sh_q        <= '0;
      freq_q      <= '0;
      bcd_q       <= '0;
      step_q      <= '0;
      dz_q        <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Raise valid on a new result, drop it once the receiver takes the beat
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_status_i.empty) begin
            prod_q  <= {{W{1'b0}}, job_i.gated_count} * {{W{1'b0}}, job_i.clock_count};
            ref_q   <= job_i.reference_count;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          step_q <= '0;
          bcd_q  <= '0;
          dz_q   <= 1'b0;
          sat_q  <= 1'b0;
          if (ref_q == '0) begin
            dz_q    <= 1'b1;
            freq_q  <= '0;
            state_q <= S_LOAD;
          end else if (prod_q[2*W-1:W] >= ref_q) begin
            // Quotient needs more than 32 bits: clamp
            sat_q   <= 1'b1;
            freq_q  <= '1;
            sh_q    <= '1;
            state_q <= S_BCD;
          end else begin
            rem_q   <= prod_q[2*W-1:W];
            sh_q    <= prod_q[W-1:0];
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= qbit ? trial_sub[W-1:0] : trial[W-1:0];
          sh_q   <= {sh_q[W-2:0], qbit};
          step_q <= step_q + StepW'(1);
          if (step_q == '1) begin
            freq_q  <= {sh_q[W-2:0], qbit};
            state_q <= S_BCD;
          end
        end
        S_BCD: begin
          bcd_q  <= {bcd_adj[BcdW-2:0], sh_q[W-1]};
          sh_q   <= {sh_q[W-2:0], 1'b0};
          step_q <= step_q + StepW'(1);
          if (step_q == '1) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          // Hold until the output register is free
          if (load_out) begin
            out_q.frequency      <= freq_q;
            out_q.bcd_digits     <= tcffc_pkg::BcdFieldW'(bcd_q);
            out_q.divide_by_zero <= dz_q;
            out_q.saturated      <= sat_q;
            state_q              <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < ref_q) else $error("divide remainder not below divisor");
  a_dz_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |->
      out_data_o.frequency == '0 && out_data_o.bcd_digits == '0 && !out_data_o.saturated)
    else $error("divide by zero result not cleared");
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.frequency == '1)
    else $error("saturated result not clamped");
`endif

endmodule

`default_nettype wire

// ----- rtl/tagged_count_frame_frequency_calc.sv -----
// Top level of the tagged-count frame frequency calculator.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is one five-byte
// frame. A tag byte 0xAA, 0xBB or 0xCC (checked in that order, lowest byte
// position first) selects which count the four following bytes replace.
// Every FramesPerUpdate frames the three counts go to a two-entry job queue.
// Frames are taken one per cycle while the queue has room.
// Output channel (out_valid_o/out_ready_i/out_data_o): one beat per job with
// floor(clock * gated / reference), its BCD digits and the two flags.
// For each job the back end pops it and forms the product, passes a check
// state, runs 32 divide steps of a 1-bit restoring divider and 32
// double-dabble steps, and then holds in a load state until the output
// register is free. A zero reference skips both loops, a saturated quotient
// skips the divide. The back end works on one job at a time and pops the
// next only after the result is loaded.
// Reset clears the three counts, the frame count, the queue and the output.
// When the receiver stalls, the result holds in the output register, the back
// end finishes the next job and waits, and the front keeps taking frames until
// the queue fills.
`default_nettype none

module tagged_count_frame_frequency_calc #(
  parameter int unsigned FramesPerUpdate = tcffc_pkg::FramesPerUpdateD,
  parameter int unsigned DigitCount      = tcffc_pkg::DigitCountD
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tcffc_pkg::frame_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tcffc_pkg::result_t      out_data_o
);

  logic                     push, pop;
  tcffc_pkg::job_t          push_job, pop_job;
  tcffc_pkg::queue_status_t q_status;

  tcffc_front #(
    .FramesPerUpdate(FramesPerUpdate)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  tcffc_fifo #(
    .Width($bits(tcffc_pkg::job_t)),
    .Depth(tcffc_pkg::QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (q_status)
  );

  tcffc_back #(
    .DigitCount(DigitCount)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the tagged-count frame frequency calculator.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcffc_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int RandomFrames  = 650;
  localparam int HoldCycles    = 500;
  localparam int DrainCycles   = 120;
  localparam int ReportLimit   = 10;
  localparam int WellFormedPct = 85;

  // Predict each reading from the accepted frames and check results in order
  class frequency_scoreboard;
    logic [CountW-1:0]    ref_cnt;
    logic [CountW-1:0]    gated_cnt;
    logic [CountW-1:0]    clock_cnt;
    logic [FrameCntW-1:0] frames_in_period;
    result_t              expected_readings[$];
    int                   frames_taken;
    int                   readings_checked;
    int                   div0_seen;
    int                   sat_seen;
    int                   mismatches;

    function new();
      ref_cnt          = '0;
      gated_cnt        = '0;
      clock_cnt        = '0;
      frames_in_period = '0;
      frames_taken     = 0;
      readings_checked = 0;
      div0_seen        = 0;
      sat_seen         = 0;
      mismatches       = 0;
    endfunction

    function automatic logic [7:0] byte_at(frame_t f, int pos);
      return f[8*(FrameBytes-1-pos) +: 8];
    endfunction

    // Search one tag, lowest position first; the count wraps around the frame
    function automatic bit find_tag(frame_t f, logic [7:0] tag, output logic [31:0] cnt);
      cnt = '0;
      for (int p = 0; p < FrameBytes; p++) begin
        if (byte_at(f, p) == tag) begin
          for (int k = 1; k <= 4; k++) begin
            cnt = {cnt[23:0], byte_at(f, (p + k) % FrameBytes)};
          end
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void take_frame(frame_t f);
      logic [31:0] cnt;
      logic [63:0] quotient;
      logic [31:0] freq;
      result_t     r;

      frames_taken++;
      if (find_tag(f, TagReference, cnt)) begin
        ref_cnt = cnt;
      end else if (find_tag(f, TagGated, cnt)) begin
        gated_cnt = cnt;
      end else if (find_tag(f, TagClock, cnt)) begin
        clock_cnt = cnt;
      end

      frames_in_period = frames_in_period + 1'b1;
      if (frames_in_period < FramesPerUpdateD) return;
      frames_in_period = '0;

      r = '0;
      if (ref_cnt == '0) begin
        r.divide_by_zero = 1'b1;
      end else begin
        quotient = ({32'b0, clock_cnt} * {32'b0, gated_cnt}) / {32'b0, ref_cnt};
        if (quotient > 64'h0000_0000_FFFF_FFFF) begin
          freq        = 32'hFFFF_FFFF;
          r.saturated = 1'b1;
        end else begin
          freq = quotient[31:0];
        end
        r.frequency = freq;
        // Convert to decimal, least significant digit in the lowest nibble
        for (int i = 0; i < DigitCountD && i < BcdFieldW / 4; i++) begin
          r.bcd_digits[4*i +: 4] = 4'(freq % 10);
          freq = freq / 10;
        end
      end
      expected_readings.push_back(r);
    endfunction

    function void check_reading(result_t got);
      result_t want;

      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: unexpected result beat freq=%h bcd=%h dz=%b sat=%b", $time,
                   got.frequency, got.bcd_digits, got.divide_by_zero, got.saturated);
        end
        return;
      end
      want = expected_readings.pop_front();
      readings_checked++;
      if (want.divide_by_zero) div0_seen++;
      if (want.saturated) sat_seen++;
      if (got.frequency !== want.frequency || got.bcd_digits !== want.bcd_digits ||
          got.divide_by_zero !== want.divide_by_zero || got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: result mismatch", $time);
          $display("  expected freq=%h bcd=%h dz=%b sat=%b", want.frequency,
                   want.bcd_digits, want.divide_by_zero, want.saturated);
          $display("  actual   freq=%h bcd=%h dz=%b sat=%b", got.frequency,
                   got.bcd_digits, got.divide_by_zero, got.saturated);
        end
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  frame_t  in_data;
  logic    out_valid;
  logic    out_ready;
  result_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed    = 1'b0;

  frequency_scoreboard sb = new();

  tagged_count_frame_frequency_calc i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Sample both channels at the edge where a beat is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_frame(in_data);
      if (out_valid && out_ready) sb.check_reading(out_data);
    end
  end

  // Offer one frame after a random gap and hold it until accepted
  task automatic send_frame(input frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Build a frame with the tag at pos and the count in the next four bytes
  function automatic frame_t tagged_frame(logic [7:0] tag, int pos, logic [31:0] cnt);
    logic [7:0] b[FrameBytes];

    b[pos] = tag;
    for (int k = 1; k <= 4; k++) begin
      b[(pos + k) % FrameBytes] = cnt[8*(4-k) +: 8];
    end
    return {b[0], b[1], b[2], b[3], b[4]};
  endfunction

  function automatic logic [31:0] random_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(255));
      3:       return 32'($urandom_range(65535));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] random_tag();
    case ($urandom_range(2))
      0:       return TagReference;
      1:       return TagGated;
      default: return TagClock;
    endcase
  endfunction

  // Mostly whole periods of tagged frames; the rest is raw noise that shifts alignment
  task automatic send_random_frames(input int n);
    int sent;

    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < WellFormedPct) begin
        repeat (FramesPerUpdateD) begin
          send_frame(tagged_frame(random_tag(), $urandom_range(FrameBytes - 1),
                                  random_count()));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 2)) begin
          send_frame(frame_t'({$urandom(), 8'($urandom())}));
          sent++;
        end
      end
    end
  endtask

  // Drop ready at random; once armed, hold it low for a long stretch
  initial begin
    bit hold_done;

    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No tag anywhere, then a zero reference: divide flag
    send_frame(40'h00_00_00_00_00);
    send_frame(40'hFF_FF_FF_FF_FF);
    send_frame(tagged_frame(TagReference, 0, 32'h0));
    // Ordinary quotient, count wrapping past the frame end
    send_frame(tagged_frame(TagReference, 4, 32'h0102_0304));
    send_frame(tagged_frame(TagGated, 2, 32'h89AB_CDEF));
    send_frame(tagged_frame(TagClock, 1, 32'h00FF_00FF));
    // Largest product over reference one: clamp
    send_frame(tagged_frame(TagReference, 0, 32'h1));
    send_frame(tagged_frame(TagGated, 3, 32'hFFFF_FFFF));
    send_frame(tagged_frame(TagClock, 2, 32'hFFFF_FFFF));
    // Clock count of one, a frame with no tag, then several tags in one frame
    send_frame(tagged_frame(TagClock, 0, 32'h1));
    send_frame(40'h12_34_56_78_9A);
    send_frame(40'hCC_BB_AA_11_22);
    // All counts at maximum: quotient exactly at the top without clamping
    send_frame(tagged_frame(TagReference, 1, 32'hFFFF_FFFF));
    send_frame(tagged_frame(TagGated, 4, 32'hFFFF_FFFF));
    send_frame(tagged_frame(TagClock, 3, 32'hFFFF_FFFF));
    // Quotient one past 32 bits
    send_frame(tagged_frame(TagReference, 2, 32'h1));
    send_frame(tagged_frame(TagGated, 1, 32'h0001_0000));
    send_frame(tagged_frame(TagClock, 4, 32'h0001_0000));
    // Zero clock count, repeated gated tags, reference tag at the fourth byte
    send_frame(tagged_frame(TagClock, 0, 32'h0));
    send_frame(40'hBB_CC_BB_CC_BB);
    send_frame(tagged_frame(TagReference, 3, 32'h0000_0007));

    send_idle_pct = 31;
    recv_idle_pct = 81;
    send_random_frames(RandomFrames / 3);
    send_idle_pct = 81;
    recv_idle_pct = 31;
    send_random_frames(RandomFrames / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    send_random_frames(RandomFrames - 2 * (RandomFrames / 3));

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d frames and checked %0d results (%0d zero reference, %0d clamped).",
             sb.frames_taken, sb.readings_checked, sb.div0_seen, sb.sat_seen);
    $display("Idle mixes 31/81, 81/31 and none plus one long output stall; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tagged_count_frame_frequency_calc regression: pass");
    end else begin
      $display("tagged_count_frame_frequency_calc regression: fail");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", sb.pending());
    $display("tagged_count_frame_frequency_calc regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
